/* rtl/rlcd_pkg.sv */
// ----------------------------------------------------------------------------
// rlcd_pkg: shared types and constants for the relay/LED command deframer
// Frame codes, phase encoding, item/result structs and register indexes.
// ----------------------------------------------------------------------------
package rlcd_pkg;

    // Width of the pull-in countdown; hold_delay is cut or widened to it.
    localparam int DELAY_BITS = 16;

    localparam logic [7:0] SYNC_BYTE     = 8'hA0;
    localparam logic [7:0] CODE_RELAY    = 8'h01;
    localparam logic [7:0] CODE_RED      = 8'h11;
    localparam logic [7:0] CODE_GREEN    = 8'h12;
    localparam logic [7:0] CODE_BLUE     = 8'h13;
    localparam logic [7:0] CODE_POLL_ONE = 8'h21;
    localparam logic [7:0] CODE_POLL_TWO = 8'h22;

    localparam logic [7:0]  FULL_DUTY_RST  = 8'd255;
    localparam logic [7:0]  HOLD_DUTY_RST  = 8'd130;
    localparam logic [15:0] HOLD_DELAY_RST = 16'd100;

    // Item kind carried on tuser
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_FULL_DUTY  = 2'd0;
    localparam logic [1:0] REG_HOLD_DUTY  = 2'd1;
    localparam logic [1:0] REG_HOLD_DELAY = 2'd2;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_CODE    = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_CHECK   = 2'd3
    } phase_t;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
        logic       button_one;
        logic       button_two;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  full_duty;
        logic [7:0]  hold_duty;
        logic [15:0] hold_delay;
    } cfg_t;

    typedef struct packed {
        logic [7:0] relay_duty;
        logic       red_on;
        logic       green_on;
        logic [7:0] blue_duty;
        logic       frame_good;
        logic       frame_bad;
        logic       poll_valid;
        logic       poll_which;
        logic       poll_level;
    } res_t;

endpackage

/* rtl/rlcd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// rlcd_cfg_regs: configuration register file
// Write-only registers for relay full duty, hold duty and pull-in delay.
// ----------------------------------------------------------------------------
module rlcd_cfg_regs
    import rlcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                REG_FULL_DUTY:  cfg_next.full_duty  = cfg_wdata[7:0];
                REG_HOLD_DUTY:  cfg_next.hold_duty  = cfg_wdata[7:0];
                REG_HOLD_DELAY: cfg_next.hold_delay = cfg_wdata;
                default:        cfg_next = cfg_reg;   // unmapped index: ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.full_duty  <= FULL_DUTY_RST;
            cfg_reg.hold_duty  <= HOLD_DUTY_RST;
            cfg_reg.hold_delay <= HOLD_DELAY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/rlcd_in_reg.sv */
// ----------------------------------------------------------------------------
// rlcd_in_reg: input register stage
// Captures one incoming transfer; refills in the cycle it is consumed.
// ----------------------------------------------------------------------------
module rlcd_in_reg
    import rlcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  in_item_t    s_item,
    input  logic        advance,
    output logic        item_valid,
    output in_item_t    item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    in_item_t item_next;

    assign s_tready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (s_tready)
        begin
            valid_next = s_tvalid;
            item_next  = s_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* rtl/rlcd_core.sv */
// ----------------------------------------------------------------------------
// rlcd_core: frame decoder, output state and result register
// One item per cycle if unstalled: framing FSM, LED/relay state, pull-in count.
// ----------------------------------------------------------------------------
module rlcd_core
    import rlcd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     item_valid,
    input  in_item_t item,
    output logic     advance,
    output logic     res_valid,
    output res_t     res,
    input  logic     m_tready
);

    phase_t                phase_reg, phase_next;
    logic [7:0]            code_reg, code_next;
    logic [7:0]            payload_reg, payload_next;
    logic [7:0]            sum_reg, sum_next;
    logic [7:0]            relay_reg, relay_next;
    logic                  red_reg, red_next;
    logic                  green_reg, green_next;
    logic [7:0]            blue_reg, blue_next;
    logic [DELAY_BITS-1:0] count_reg, count_next;
    logic                  res_valid_reg, res_valid_next;
    res_t                  res_reg, res_next;

    logic take;
    logic is_byte;
    logic sum_match;
    logic [DELAY_BITS-1:0] delay_load;
    logic [DELAY_BITS-1:0] count_dec;

    assign advance    = !res_valid_reg || m_tready;
    assign take       = item_valid && advance;
    assign is_byte    = (item.command == CMD_BYTE);
    assign sum_match  = (item.rx_byte == sum_reg);
    assign delay_load = DELAY_BITS'(cfg.hold_delay);
    assign count_dec  = count_reg - DELAY_BITS'(1);

    // Frame phase
    always_comb
    begin
        phase_next = phase_reg;
        if (take && is_byte)
        begin
            case (phase_reg)
                PH_HUNT:    phase_next = (item.rx_byte == SYNC_BYTE) ? PH_CODE : PH_HUNT;
                PH_CODE:    phase_next = PH_PAYLOAD;
                PH_PAYLOAD: phase_next = PH_CHECK;
                PH_CHECK:   phase_next = PH_HUNT;  // good or bad, back to hunting
                default:    phase_next = PH_HUNT;
            endcase
        end
    end

    // Datapath and result
    always_comb
    begin
        code_next      = code_reg;
        payload_next   = payload_reg;
        sum_next       = sum_reg;
        relay_next     = relay_reg;
        red_next       = red_reg;
        green_next     = green_reg;
        blue_next      = blue_reg;
        count_next     = count_reg;
        res_valid_next = res_valid_reg && !m_tready;
        res_next       = res_reg;
        res_next.frame_good = 1'b0;
        res_next.frame_bad  = 1'b0;
        res_next.poll_valid = 1'b0;
        res_next.poll_which = 1'b0;
        res_next.poll_level = 1'b0;

        if (take)
        begin
            res_valid_next = 1'b1;
            if (!is_byte)
            begin
                if (count_reg != '0)
                begin
                    count_next = count_dec;
                    if (count_dec == '0)
                    begin
                        relay_next = cfg.hold_duty;
                    end
                end
            end
            else
            begin
                case (phase_reg)
                    PH_HUNT:
                    begin
                        if (item.rx_byte == SYNC_BYTE)
                        begin
                            sum_next = SYNC_BYTE;
                        end
                    end
                    PH_CODE:
                    begin
                        code_next = item.rx_byte;
                        sum_next  = sum_reg + item.rx_byte;
                    end
                    PH_PAYLOAD:
                    begin
                        payload_next = item.rx_byte;
                        sum_next     = sum_reg + item.rx_byte;
                    end
                    PH_CHECK:
                    begin
                        res_next.frame_good = sum_match;
                        res_next.frame_bad  = !sum_match;
                        if (sum_match)
                        begin
                            case (code_reg)
                                CODE_RELAY:
                                begin
                                    if (payload_reg != 8'd0)
                                    begin
                                        relay_next = cfg.full_duty;
                                        if (cfg.full_duty > 8'd1)
                                        begin
                                            count_next = delay_load;
                                            if (delay_load == '0)
                                            begin
                                                relay_next = cfg.hold_duty;
                                            end
                                        end
                                        else
                                        begin
                                            count_next = '0;
                                        end
                                    end
                                    else
                                    begin
                                        relay_next = 8'd0;
                                        count_next = '0;
                                    end
                                end
                                CODE_RED:   red_next   = (payload_reg != 8'd0);
                                CODE_GREEN: green_next = (payload_reg != 8'd0);
                                CODE_BLUE:  blue_next  = payload_reg;
                                CODE_POLL_ONE:
                                begin
                                    res_next.poll_valid = 1'b1;
                                    res_next.poll_which = 1'b0;
                                    res_next.poll_level = item.button_one;
                                end
                                CODE_POLL_TWO:
                                begin
                                    res_next.poll_valid = 1'b1;
                                    res_next.poll_which = 1'b1;
                                    res_next.poll_level = item.button_two;
                                end
                                default: ;  // unknown code: still a good frame
                            endcase
                        end
                    end
                    default: ;
                endcase
            end
            res_next.relay_duty = relay_next;
            res_next.red_on     = red_next;
            res_next.green_on   = green_next;
            res_next.blue_duty  = blue_next;
        end
        else if (res_valid_reg && !m_tready)
        begin
            res_next = res_reg;     // stalled result holds
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            code_reg      <= 8'd0;
            payload_reg   <= 8'd0;
            sum_reg       <= 8'd0;
            relay_reg     <= 8'd0;
            red_reg       <= 1'b1;
            green_reg     <= 1'b0;
            blue_reg      <= 8'd0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            code_reg      <= code_next;
            payload_reg   <= payload_next;
            sum_reg       <= sum_next;
            relay_reg     <= relay_next;
            red_reg       <= red_next;
            green_reg     <= green_next;
            blue_reg      <= blue_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // A poll report only comes with a good frame
    a_poll_needs_good: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.poll_valid |-> res_reg.frame_good)
        else $error("poll reported without good frame");

    // A running pull-in implies the relay is driven above 1
    a_pullin_relay: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 |-> relay_reg > 8'd1)
        else $error("pull-in running with relay duty <= 1");

    // Ticks never move the framing state
    a_tick_keeps_phase: assert property (@(posedge clk) disable iff (!rst_n)
        take && !is_byte |=> $stable(phase_reg))
        else $error("tick changed frame phase");

    // The checksum byte always ends the frame
    a_check_returns: assert property (@(posedge clk) disable iff (!rst_n)
        take && is_byte && phase_reg == PH_CHECK |=> phase_reg == PH_HUNT)
        else $error("frame did not return to hunting");

endmodule

/* rtl/relay_led_command_deframer.sv */
// Path: an accepted transfer passes the input register, then the result
//   register, before its result appears on m_axis; a stall on m_axis can
//   hold it back in the input register.
// Throughput: one item per cycle while m_axis is not stalled; the framing
//   FSM and relay countdown update combinationally between the registers.
// Reset (rst_n, async, active low): hunting for sync, relay 0, red on,
//   green off, blue 0, no pull-in; registers 255 / 130 / 100.
// ----------------------------------------------------------------------------
// relay_led_command_deframer: serial command deframer for relay and LEDs
// Frames sync/code/payload/checksum bytes, drives relay duty with pull-in
// and hold phases, LED levels, and reports button polls.
// ----------------------------------------------------------------------------
module relay_led_command_deframer
    import rlcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] rx_byte, [8] button_one, [9] button_two
    input  logic        s_axis_tuser,   // [0] command (0 byte, 1 tick)
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [7:0] relay_duty, [8] red_on, [9] green_on,
                                        // [17:10] blue_duty, [18] frame_good,
                                        // [19] frame_bad, [20] poll_valid,
                                        // [21] poll_which, [22] poll_level
);

    cfg_t     cfg;
    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     advance;
    res_t     res;

    // Unpack the slave-side transfer
    assign s_item.command    = s_axis_tuser;
    assign s_item.rx_byte    = s_axis_tdata[7:0];
    assign s_item.button_one = s_axis_tdata[8];
    assign s_item.button_two = s_axis_tdata[9];

    rlcd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Input register: refills in the same cycle the core consumes it
    rlcd_in_reg u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_axis_tvalid),
        .s_tready   (s_axis_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // Decode and state update; result register decouples the master side
    rlcd_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .res_valid  (m_axis_tvalid),
        .res        (res),
        .m_tready   (m_axis_tready)
    );

    // Pack the result, first field lowest, top bit padding
    assign m_axis_tdata = {1'b0,
                           res.poll_level,
                           res.poll_which,
                           res.poll_valid,
                           res.frame_bad,
                           res.frame_good,
                           res.blue_duty,
                           res.green_on,
                           res.red_on,
                           res.relay_duty};

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for relay_led_command_deframer
// Streams serial bytes and ms ticks in, predicts every status transfer with
// an in-bench deframer model and checks it field by field. Both stream
// sides idle at random; the registers are rewritten between traffic phases.
// ----------------------------------------------------------------------------
module tb;
    import rlcd_pkg::*;

    localparam int         CYCLE_LIMIT = 500000;
    localparam logic [1:0] REG_UNUSED  = 2'd3;   // no register here, write must be ignored

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // [7:0] rx_byte, [8] button_one, [9] button_two
    logic        s_axis_tuser = 1'b0; // [0] command (0 byte, 1 tick)
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // [7:0] relay_duty, [8] red_on, [9] green_on,
                                      // [17:10] blue_duty, [18] frame_good,
                                      // [19] frame_bad, [20] poll_valid,
                                      // [21] poll_which, [22] poll_level

    relay_led_command_deframer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Bookkeeping
    // ------------------------------------------------------------------
    in_item_t pending_items[$];    // bytes/ticks not yet handed to the driver
    res_t     expected_status[$];  // predicted status transfers, oldest first
    int       items_queued  = 0;
    int       results_seen  = 0;
    int       error_count   = 0;
    int       cycle_count   = 0;

    // ------------------------------------------------------------------
    // Deframer model: shadow registers and state
    // ------------------------------------------------------------------
    logic [7:0]            full_duty_cfg;
    logic [7:0]            hold_duty_cfg;
    logic [15:0]           hold_delay_cfg;
    phase_t                framing;
    logic [7:0]            frame_code;
    logic [7:0]            frame_payload;
    logic [7:0]            frame_sum;
    logic [7:0]            relay_lvl;
    logic                  red_lvl;
    logic                  green_lvl;
    logic [7:0]            blue_lvl;
    logic [DELAY_BITS-1:0] pull_in_left;

    task automatic reset_model();
        full_duty_cfg  = FULL_DUTY_RST;
        hold_duty_cfg  = HOLD_DUTY_RST;
        hold_delay_cfg = HOLD_DELAY_RST;
        framing        = PH_HUNT;
        frame_code     = '0;
        frame_payload  = '0;
        frame_sum      = '0;
        relay_lvl      = '0;
        red_lvl        = 1'b1;   // red comes up lit
        green_lvl      = 1'b0;
        blue_lvl       = '0;
        pull_in_left   = '0;
    endtask

    // Advance the model by one byte or tick, return the status it must show.
    function automatic res_t deframe_step(in_item_t item);
        res_t r;
        r = '0;
        if (item.command == CMD_TICK)
        begin
            // ticks only run the pull-in countdown, framing is untouched
            if (pull_in_left != 0)
            begin
                pull_in_left = pull_in_left - 1'b1;
                if (pull_in_left == 0)
                    relay_lvl = hold_duty_cfg;
            end
        end
        else
        begin
            case (framing)
                PH_HUNT:
                begin
                    if (item.rx_byte == SYNC_BYTE)
                    begin
                        frame_sum = SYNC_BYTE;
                        framing   = PH_CODE;
                    end
                end
                PH_CODE:
                begin
                    frame_code = item.rx_byte;
                    frame_sum  = frame_sum + item.rx_byte;
                    framing    = PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    frame_payload = item.rx_byte;
                    frame_sum     = frame_sum + item.rx_byte;
                    framing       = PH_CHECK;
                end
                default:
                begin
                    // checksum byte: back to hunting either way, and a bad
                    // checksum byte is never taken as a fresh sync
                    framing = PH_HUNT;
                    if (item.rx_byte != frame_sum)
                        r.frame_bad = 1'b1;
                    else
                    begin
                        r.frame_good = 1'b1;
                        case (frame_code)
                            CODE_RELAY:
                            begin
                                if (frame_payload != 0)
                                begin
                                    relay_lvl = full_duty_cfg;
                                    if (relay_lvl > 1)
                                    begin
                                        // (re)start pull-in; zero delay holds at once
                                        pull_in_left = DELAY_BITS'(hold_delay_cfg);
                                        if (pull_in_left == 0)
                                            relay_lvl = hold_duty_cfg;
                                    end
                                    else
                                        pull_in_left = '0;
                                end
                                else
                                begin
                                    relay_lvl    = '0;
                                    pull_in_left = '0;
                                end
                            end
                            CODE_RED:   red_lvl   = (frame_payload != 0);
                            CODE_GREEN: green_lvl = (frame_payload != 0);
                            CODE_BLUE:  blue_lvl  = frame_payload;
                            CODE_POLL_ONE:
                            begin
                                r.poll_valid = 1'b1;
                                r.poll_level = item.button_one;
                            end
                            CODE_POLL_TWO:
                            begin
                                r.poll_valid = 1'b1;
                                r.poll_which = 1'b1;
                                r.poll_level = item.button_two;
                            end
                            default: ;   // unknown code: acknowledged, no effect
                        endcase
                    end
                end
            endcase
        end
        r.relay_duty = relay_lvl;
        r.red_on     = red_lvl;
        r.green_on   = green_lvl;
        r.blue_duty  = blue_lvl;
        return r;
    endfunction

    // Mirror register writes and predict every accepted input transfer.
    // Sampled at the edge, so both see the values the DUT sees.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_FULL_DUTY:  full_duty_cfg  = cfg_wdata[7:0];
                    REG_HOLD_DUTY:  hold_duty_cfg  = cfg_wdata[7:0];
                    REG_HOLD_DELAY: hold_delay_cfg = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_status.push_back(deframe_step('{
                    command:    s_axis_tuser,
                    rx_byte:    s_axis_tdata[7:0],
                    button_one: s_axis_tdata[8],
                    button_two: s_axis_tdata[9]}));
        end
    end

    // ------------------------------------------------------------------
    // Idle draws: random idle gaps between transfers, with calm stretches of no idling
    // ------------------------------------------------------------------
    bit src_calm  = 1'b0;
    bit sink_calm = 1'b0;
    int src_gap   = 0;
    int sink_wait = 0;

    function automatic int draw_gap(ref bit calm);
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, 8);
    endfunction

    // Input driver: keeps data stable while stalled, idles between transfers.
    always @(posedge clk)
    begin
        in_item_t item;
        if (rst_n && !(s_axis_tvalid && !s_axis_tready))
        begin
            if (src_gap > 0)
            begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                item = pending_items.pop_front();
                s_axis_tdata  <= {6'b0, item.button_two, item.button_one, item.rx_byte};
                s_axis_tuser  <= item.command;
                s_axis_tvalid <= 1'b1;
                src_gap = draw_gap(src_calm);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and checker
    // ------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic compare_field(string name, int got, int want);
        if (got != want)
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    task automatic check_status(logic [23:0] d);
        res_t want;
        if (expected_status.size() == 0)
        begin
            report_mismatch($sformatf("status transfer 0x%06h with none expected", d));
            return;
        end
        want = expected_status.pop_front();
        compare_field("relay_duty", d[7:0],   want.relay_duty);
        compare_field("red_on",     d[8],     want.red_on);
        compare_field("green_on",   d[9],     want.green_on);
        compare_field("blue_duty",  d[17:10], want.blue_duty);
        compare_field("frame_good", d[18],    want.frame_good);
        compare_field("frame_bad",  d[19],    want.frame_bad);
        compare_field("poll_valid", d[20],    want.poll_valid);
        compare_field("poll_which", d[21],    want.poll_which);
        compare_field("poll_level", d[22],    want.poll_level);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_status(m_axis_tdata);
                results_seen++;
                sink_wait = draw_gap(sink_calm);
            end
            // backpressure applies whether or not a transfer is pending
            if (sink_wait > 0)
            begin
                sink_wait--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_item(logic cmd, logic [7:0] b);
        pending_items.push_back('{command: cmd, rx_byte: b,
                                  button_one: 1'($urandom), button_two: 1'($urandom)});
        items_queued++;
    endtask

    task automatic queue_ticks(int n);
        repeat (n) queue_item(CMD_TICK, 8'($urandom));  // byte lane ignored on ticks
    endtask

    // sync/code/payload/checksum, optionally with ticks woven in between
    task automatic queue_frame(logic [7:0] code, logic [7:0] payload,
                               bit corrupt, bit with_ticks);
        logic [7:0] chk;
        chk = SYNC_BYTE + code + payload;
        if (corrupt)
            chk = chk + 8'($urandom_range(1, 255));
        queue_item(CMD_BYTE, SYNC_BYTE);
        if (with_ticks) queue_ticks($urandom_range(0, 2));
        queue_item(CMD_BYTE, code);
        if (with_ticks) queue_ticks($urandom_range(0, 2));
        queue_item(CMD_BYTE, payload);
        if (with_ticks) queue_ticks($urandom_range(0, 2));
        queue_item(CMD_BYTE, chk);
    endtask

    // Mostly well-formed frames with random content; the rest is tick
    // bursts, line noise and frames cut short.
    task automatic random_traffic(int n);
        int         start;
        logic [7:0] code;
        logic [7:0] payload;
        start = items_queued;
        while (items_queued - start < n)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2:
                    queue_ticks($urandom_range(1, 6));
                3, 4:
                    repeat ($urandom_range(1, 3)) queue_item(CMD_BYTE, 8'($urandom));
                5:
                begin
                    // sync then a partial frame that runs into what follows
                    queue_item(CMD_BYTE, SYNC_BYTE);
                    repeat ($urandom_range(0, 2)) queue_item(CMD_BYTE, 8'($urandom));
                end
                default:
                begin
                    case ($urandom_range(0, 8))
                        0, 1:    code = CODE_RELAY;
                        2:       code = CODE_RED;
                        3:       code = CODE_GREEN;
                        4:       code = CODE_BLUE;
                        5:       code = CODE_POLL_ONE;
                        6:       code = CODE_POLL_TWO;
                        default: code = 8'($urandom);
                    endcase
                    payload = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
                    queue_frame(code, payload, $urandom_range(0, 9) == 0,
                                $urandom_range(0, 2) == 0);
                end
            endcase
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // upper bits of the 8-bit registers carry junk that must be dropped
    task automatic set_regs(logic [7:0] full, logic [7:0] hold, logic [15:0] delay);
        write_reg(REG_FULL_DUTY,  {8'($urandom), full});
        write_reg(REG_HOLD_DUTY,  {8'($urandom), hold});
        write_reg(REG_HOLD_DELAY, delay);
    endtask

    // Wait until every queued item has come back, then let the pipe settle.
    task automatic wait_drained();
        wait (pending_items.size() == 0 && results_seen == items_queued);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        reset_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:
                begin
                    // reset registers; directed sweep first
                    queue_frame(CODE_RELAY, 8'h01, 1'b0, 1'b0);   // pull-in starts
                    queue_ticks(2);
                    queue_frame(CODE_POLL_ONE, 8'h00, 1'b0, 1'b0);
                    queue_frame(CODE_BLUE, 8'hFF, 1'b0, 1'b0);
                    // bad checksum that happens to be the sync value
                    queue_item(CMD_BYTE, SYNC_BYTE);
                    queue_item(CMD_BYTE, CODE_RED);
                    queue_item(CMD_BYTE, 8'h00);
                    queue_item(CMD_BYTE, SYNC_BYTE);
                    queue_frame(CODE_RELAY, 8'h00, 1'b0, 1'b0);   // relay off, pull-in cancelled
                end
                1: set_regs(8'd255, 8'd0, 16'd0);       // zero delay: hold applies at once
                2: set_regs(8'd0, 8'd255, 16'hFFFF);    // relay on gives duty 0
                3:
                begin
                    set_regs(8'd1, 8'd77, 16'd1);       // duty 1: no pull-in
                    write_reg(REG_UNUSED, 16'($urandom));
                end
                4: set_regs(8'd2, 8'd1, 16'd3);
                default: set_regs(8'($urandom), 8'($urandom), 16'($urandom_range(0, 12)));
            endcase
            random_traffic(210);
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (expected_status.size() != 0)
            report_mismatch($sformatf("%0d status transfers never arrived",
                                      expected_status.size()));
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
